### hw/rtl/ffdx_pkg.sv
package ffdx_pkg;

    // Frame geometry. Every position below follows from the frame length.
    localparam int FRAME_LEN = 13;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    // The body cells hold frame bytes 3 up to the checksum byte.
    localparam int CHAIN_LEN = FRAME_LEN - 4;

    localparam logic [7:0] SOF_BYTE  = 8'hAA;
    localparam logic [7:0] HDR1_BYTE = 8'hBB;
    localparam logic [7:0] HDR2_BYTE = 8'hCC;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;
    localparam int         BODY_START = 3;

    typedef enum logic [1:0] {
        PH_SOF  = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SOF       = 3'd1,
        ST_HEADER    = 3'd2,
        ST_BODY      = 3'd3,
        ST_NOT_SOF   = 3'd4,
        ST_BAD_HDR   = 3'd5,
        ST_BAD_CHECK = 3'd6
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               frame_valid;
        logic signed [15:0] pitch_centideg;
        logic signed [15:0] yaw_centideg;
        logic [7:0]         target_ids;
        logic [7:0]         flight_time;
        logic [3:0]         detect_state;
        logic [1:0]         target_color;
        logic [1:0]         shoot_code;
        logic [7:0]         aim_x;
        logic [7:0]         aim_y;
    } res_t;

endpackage

### hw/rtl/fixed_frame_deframer_xor_check_core.sv
// Fixed-length frame deframer with XOR check. Each received byte is one input
// beat and produces exactly one status beat; the beat that carries the tail of
// a good frame also carries the decoded pitch, yaw, target, state and aim
// fields, and every other beat carries zeros there. A byte is taken in every
// clock cycle while the output buffer is not full: the parser decides each
// byte combinationally from its phase, a running XOR of the checked body bytes
// and a row of byte cells that shift the body along one cell per body byte, so
// the body bytes and checksum sit in the row when the tail arrives. Results
// leave through a registered two-entry output buffer, so one result may wait on
// a stalled output while the next byte is still taken. buff_mode lives in the
// register at byte address 0 and is sampled on the byte that ends a frame.
module fixed_frame_deframer_xor_check_core (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Received byte stream.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    // Status stream.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic               frame_valid,
    output logic signed [15:0] pitch_centideg,
    output logic signed [15:0] yaw_centideg,
    output logic [7:0]         target_ids,
    output logic [7:0]         flight_time,
    output logic [3:0]         detect_state,
    output logic [1:0]         target_color,
    output logic [1:0]         shoot_code,
    output logic [7:0]         aim_x,
    output logic [7:0]         aim_y
);
    import ffdx_pkg::*;

    // Word index of the only register.
    localparam logic CFG_BUFF_MODE = 1'b0;

    // Frame byte i sits in cell FRAME_LEN-2-i once the tail byte arrives.
    localparam int CELL_CHECK = 0;
    localparam int CELL_B3    = FRAME_LEN - 2 - 3;
    localparam int CELL_B4    = FRAME_LEN - 2 - 4;
    localparam int CELL_B5    = FRAME_LEN - 2 - 5;
    localparam int CELL_B6    = FRAME_LEN - 2 - 6;
    localparam int CELL_B7    = FRAME_LEN - 2 - 7;
    localparam int CELL_B8    = FRAME_LEN - 2 - 8;
    localparam int CELL_B9    = FRAME_LEN - 2 - 9;
    localparam int CELL_B10   = FRAME_LEN - 2 - 10;

    localparam logic [IDX_W-1:0] IDX_HDR1      = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_HDR2      = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_BODY      = IDX_W'(BODY_START);
    localparam logic [IDX_W-1:0] IDX_LAST_SUM  = IDX_W'(FRAME_LEN - 3);
    localparam logic [IDX_W-1:0] IDX_TAIL      = IDX_W'(FRAME_LEN - 1);

    logic             buff_mode_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic             accept;
    logic             shift_en;
    logic [7:0]       cell_q [CHAIN_LEN];
    res_t             result;
    res_t             out_res;
    logic             cfg_write;

    // Configuration: writes land on the access cycle; pready never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == CFG_BUFF_MODE) ? {31'b0, buff_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buff_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == CFG_BUFF_MODE))
        begin
            buff_mode_reg <= pwdata[0];
        end
    end

    assign accept   = in_valid && !in_stall;
    // Body bytes, tail included, move the cell row along by one.
    assign shift_en = accept && (phase_reg == PH_BODY);

    // Row of body cells. Cell 0 takes the incoming byte.
    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            ffdx_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     (rx_byte),
                .d_out    (cell_q[k])
            );
        end
        else
        begin : g_tail
            ffdx_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     (cell_q[k-1]),
                .d_out    (cell_q[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SOF;
            index_reg <= '0;
            xor_reg   <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            xor_reg   <= xor_next;
        end
    end

    // Per-byte decision. Everything except status stays zero unless the byte
    // ends a frame whose tail and checksum are good.
    always_comb
    begin
        phase_next = PH_SOF;
        index_next = '0;
        xor_next   = xor_reg;
        result     = '0;
        case (phase_reg)
            PH_HDR:
            begin
                if ((rx_byte == HDR1_BYTE) && (index_reg == IDX_HDR1))
                begin
                    phase_next    = PH_HDR;
                    index_next    = IDX_HDR2;
                    result.status = ST_HEADER;
                end
                else if ((rx_byte == HDR2_BYTE) && (index_reg == IDX_HDR2))
                begin
                    phase_next    = PH_BODY;
                    index_next    = IDX_BODY;
                    xor_next      = 8'h00;
                    result.status = ST_HEADER;
                end
                else
                begin
                    // A wrong header byte drops the frame and is not retried as
                    // a start byte.
                    result.status = ST_BAD_HDR;
                end
            end
            PH_BODY:
            begin
                if (index_reg == IDX_TAIL)
                begin
                    if ((rx_byte != TAIL_BYTE) || (cell_q[CELL_CHECK] != xor_reg))
                    begin
                        result.status = ST_BAD_CHECK;
                    end
                    else
                    begin
                        result.status         = ST_OK;
                        result.frame_valid    = 1'b1;
                        result.pitch_centideg = {cell_q[CELL_B3], cell_q[CELL_B4]};
                        result.yaw_centideg   = {cell_q[CELL_B5], cell_q[CELL_B6]};
                        if (buff_mode_reg)
                        begin
                            result.flight_time = cell_q[CELL_B7];
                        end
                        else
                        begin
                            result.target_ids = cell_q[CELL_B7];
                        end
                        result.detect_state = cell_q[CELL_B8][7:4];
                        result.target_color = cell_q[CELL_B8][3:2];
                        result.shoot_code   = cell_q[CELL_B8][1:0];
                        result.aim_x        = cell_q[CELL_B9];
                        result.aim_y        = cell_q[CELL_B10];
                    end
                end
                else
                begin
                    phase_next    = PH_BODY;
                    index_next    = index_reg + IDX_W'(1);
                    result.status = ST_BODY;
                    // The checksum covers the body up to the byte before it.
                    if (index_reg <= IDX_LAST_SUM)
                    begin
                        xor_next = xor_reg ^ rx_byte;
                    end
                end
            end
            default:
            begin
                // Waiting for a start byte; the unused phase code acts the same.
                if (rx_byte == SOF_BYTE)
                begin
                    phase_next    = PH_HDR;
                    index_next    = IDX_HDR1;
                    result.status = ST_SOF;
                end
                else
                begin
                    result.status = ST_NOT_SOF;
                end
            end
        endcase
    end

    ffdx_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (result),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_res),
        .out_stall (out_stall)
    );

    assign status         = out_res.status;
    assign frame_valid    = out_res.frame_valid;
    assign pitch_centideg = out_res.pitch_centideg;
    assign yaw_centideg   = out_res.yaw_centideg;
    assign target_ids     = out_res.target_ids;
    assign flight_time    = out_res.flight_time;
    assign detect_state   = out_res.detect_state;
    assign target_color   = out_res.target_color;
    assign shoot_code     = out_res.shoot_code;
    assign aim_x          = out_res.aim_x;
    assign aim_y          = out_res.aim_y;

endmodule

### hw/rtl/ffdx_cell.sv
module ffdx_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] d_out
);
    import ffdx_pkg::*;

    logic [7:0] byte_reg;

    // Each cell takes its neighbor's byte whenever a body byte arrives.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= d_in;
        end
    end

    assign d_out = byte_reg;

endmodule

### hw/rtl/ffdx_skid.sv
module ffdx_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ffdx_pkg::res_t  in_data,
    output logic            in_stall,
    output logic            out_valid,
    output ffdx_pkg::res_t  out_data,
    input  logic            out_stall
);
    import ffdx_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic push;
    logic pop;

    // The skid entry only fills while the main entry is held, so a full skid
    // entry is the one condition that holds off the upstream side.
    assign in_stall  = skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!main_valid_reg || pop)
            begin
                main_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            if (push)
            begin
                main_reg <= in_data;
            end
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

import ffdx_pkg::*;

// Shadow of the deframer: it follows the received byte stream beat by beat and
// keeps the status beats the block owes, oldest first.
class deframer_scoreboard;
    phase_t      parse_phase;
    int unsigned byte_idx;
    logic [7:0]  frame_buf [FRAME_LEN];
    bit          buff_mode;
    res_t        status_due_q [$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned frames_good;
    int unsigned frames_dropped;
    int unsigned frames_buff;

    function new();
        parse_phase    = PH_SOF;
        byte_idx       = 0;
        buff_mode      = 1'b0;
        mismatches     = 0;
        beats_checked  = 0;
        frames_good    = 0;
        frames_dropped = 0;
        frames_buff    = 0;
    endfunction

    function void set_buff_mode(bit mode);
        buff_mode = mode;
    endfunction

    function int unsigned pending();
        return status_due_q.size();
    endfunction

    // Works out the status beat that one received byte causes.
    function void take_rx_byte(logic [7:0] b);
        res_t       r;
        logic [7:0] sum;
        int         i;
        r = '0;
        case (parse_phase)
            PH_HDR:
            begin
                if (b == HDR1_BYTE && byte_idx == 1)
                begin
                    frame_buf[1] = b;
                    byte_idx     = 2;
                    r.status     = ST_HEADER;
                end
                else if (b == HDR2_BYTE && byte_idx == 2)
                begin
                    frame_buf[2] = b;
                    byte_idx     = 3;
                    parse_phase  = PH_BODY;
                    r.status     = ST_HEADER;
                end
                else
                begin
                    parse_phase = PH_SOF;
                    byte_idx    = 0;
                    r.status    = ST_BAD_HDR;
                    frames_dropped++;
                end
            end
            PH_BODY:
            begin
                r.status = ST_BODY;
                if (byte_idx < FRAME_LEN)
                begin
                    frame_buf[byte_idx] = b;
                    byte_idx++;
                end
                if (byte_idx >= FRAME_LEN)
                begin
                    sum = 8'h00;
                    for (i = BODY_START; i < FRAME_LEN - 2; i++)
                        sum ^= frame_buf[i];
                    if (frame_buf[FRAME_LEN-1] != TAIL_BYTE ||
                        sum != frame_buf[FRAME_LEN-2])
                    begin
                        r.status = ST_BAD_CHECK;
                        frames_dropped++;
                    end
                    else
                    begin
                        r.status         = ST_OK;
                        r.frame_valid    = 1'b1;
                        r.pitch_centideg = {frame_buf[3], frame_buf[4]};
                        r.yaw_centideg   = {frame_buf[5], frame_buf[6]};
                        if (buff_mode)
                        begin
                            r.flight_time = frame_buf[7];
                            frames_buff++;
                        end
                        else
                        begin
                            r.target_ids = frame_buf[7];
                        end
                        r.detect_state = frame_buf[8][7:4];
                        r.target_color = frame_buf[8][3:2];
                        r.shoot_code   = frame_buf[8][1:0];
                        r.aim_x        = frame_buf[9];
                        r.aim_y        = frame_buf[10];
                        frames_good++;
                    end
                    parse_phase = PH_SOF;
                    byte_idx    = 0;
                end
            end
            default:
            begin
                if (b == SOF_BYTE)
                begin
                    frame_buf[0] = b;
                    byte_idx     = 1;
                    parse_phase  = PH_HDR;
                    r.status     = ST_SOF;
                end
                else
                begin
                    parse_phase = PH_SOF;
                    byte_idx    = 0;
                    r.status    = ST_NOT_SOF;
                end
            end
        endcase
        status_due_q.push_back(r);
    endfunction

    function string describe(res_t r);
        return $sformatf({"st=%0d fv=%0d pitch=%0d yaw=%0d ids=%02h ft=%02h ",
                          "ds=%0h col=%0d sh=%0d x=%02h y=%02h"},
                         r.status, r.frame_valid, r.pitch_centideg, r.yaw_centideg,
                         r.target_ids, r.flight_time, r.detect_state, r.target_color,
                         r.shoot_code, r.aim_x, r.aim_y);
    endfunction

    function void check_status_beat(res_t got);
        res_t want;
        beats_checked++;
        if (status_due_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("status beat with nothing due: %s", describe(got));
            return;
        end
        want = status_due_q.pop_front();
        if (got.status !== want.status || got.frame_valid !== want.frame_valid ||
            got.pitch_centideg !== want.pitch_centideg ||
            got.yaw_centideg !== want.yaw_centideg ||
            got.target_ids !== want.target_ids || got.flight_time !== want.flight_time ||
            got.detect_state !== want.detect_state ||
            got.target_color !== want.target_color ||
            got.shoot_code !== want.shoot_code ||
            got.aim_x !== want.aim_x || got.aim_y !== want.aim_y)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("status beat %0d mismatch\n  expected %s\n  actual   %s",
                         beats_checked, describe(want), describe(got));
        end
    endfunction
endclass

module tb_top;

    // Byte address of the only configuration register.
    localparam logic [2:0]  BUFF_MODE_ADDR = 3'd0;
    // Cycles with no beat moving on either side before the run is declared hung.
    // The long receiver hold below is the longest legal quiet stretch.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned PHASE_BYTES    = 460;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_TAIL,
        FLAW_HDR1,
        FLAW_HDR2
    } frame_flaw_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic               frame_valid;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] yaw_centideg;
    logic [7:0]         target_ids;
    logic [7:0]         flight_time;
    logic [3:0]         detect_state;
    logic [1:0]         target_color;
    logic [1:0]         shoot_code;
    logic [7:0]         aim_x;
    logic [7:0]         aim_y;

    deframer_scoreboard sb = new();

    // Idle rates in percent for the byte sender and the status receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // The stimulus asks for a long output hold by bumping this count.
    int unsigned hold_requests = 0;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;

    fixed_frame_deframer_xor_check_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_valid    (frame_valid),
        .pitch_centideg (pitch_centideg),
        .yaw_centideg   (yaw_centideg),
        .target_ids     (target_ids),
        .flight_time    (flight_time),
        .detect_state   (detect_state),
        .target_color   (target_color),
        .shoot_code     (shoot_code),
        .aim_x          (aim_x),
        .aim_y          (aim_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Output stall generator. Normally it stalls at random at the current rate.
    // When a hold is requested it keeps the output stalled for a long, counted
    // stretch so that the output buffer fills and the block stalls its input.
    initial
    begin : output_stall_gen
        int unsigned served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Beat monitor. Everything is sampled at the rising edge, where the block's
    // outputs and the driven inputs still hold their values from before the edge.
    // An input beat is fed to the scoreboard before the output beat of the same
    // edge is checked, so ordering holds even for a combinational path.
    always @(posedge clk)
    begin : beat_monitor
        res_t seen;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_rx_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                seen.status         = status_t'(status);
                seen.frame_valid    = frame_valid;
                seen.pitch_centideg = pitch_centideg;
                seen.yaw_centideg   = yaw_centideg;
                seen.target_ids     = target_ids;
                seen.flight_time    = flight_time;
                seen.detect_state   = detect_state;
                seen.target_color   = target_color;
                seen.shoot_code     = shoot_code;
                seen.aim_x          = aim_x;
                seen.aim_y          = aim_y;
                sb.check_status_beat(seen);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles, %0d status beats still due",
                     quiet_cycles, sb.pending());
            $display("tb_top failed");
            $finish;
        end
    end

    // Register write: a setup phase, then an access phase that completes on the
    // edge at which pready is seen high. Called at a rising edge.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every owed status beat has come back, then changes buff_mode.
    // The first edge lets the monitor note a byte taken at the calling edge.
    task automatic set_buff_mode(input bit mode);
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        write_reg(BUFF_MODE_ADDR, 32'(mode));
        sb.set_buff_mode(mode);
    endtask

    // Offers one byte after a random gap and holds it until the block takes it.
    // Valid stays high after the beat so back-to-back bytes need no second
    // assignment in the same step.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Body bytes lean toward the corners now and then so the signed angles and
    // the packed byte 8 fields see their extremes.
    function automatic logic [7:0] body_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return SOF_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Sends one whole frame. Body bytes come from the given list and are padded
    // at random; the flaw spoils one header byte, the checksum or the tail.
    task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] body[$]);
        logic [7:0] fr [FRAME_LEN];
        logic [7:0] sum;
        logic [7:0] bad;
        int         i;
        fr[0] = SOF_BYTE;
        fr[1] = HDR1_BYTE;
        fr[2] = HDR2_BYTE;
        sum   = 8'h00;
        for (i = BODY_START; i < FRAME_LEN - 2; i++)
        begin
            fr[i] = (body.size() != 0) ? body.pop_front() : body_byte();
            sum  ^= fr[i];
        end
        fr[FRAME_LEN-2] = sum;
        fr[FRAME_LEN-1] = TAIL_BYTE;
        bad = 8'($urandom_range(255));
        case (flaw)
            FLAW_CHECKSUM: fr[FRAME_LEN-2] = sum ^ 8'($urandom_range(255, 1));
            FLAW_TAIL:     fr[FRAME_LEN-1] = (bad == TAIL_BYTE) ? 8'h7F : bad;
            FLAW_HDR1:     fr[1] = (bad == HDR1_BYTE) ? HDR2_BYTE : bad;
            FLAW_HDR2:     fr[2] = (bad == HDR2_BYTE) ? HDR1_BYTE : bad;
            default:       ;
        endcase
        for (i = 0; i < FRAME_LEN; i++)
            send_byte(fr[i]);
    endtask

    // Mostly well-formed frames with random content, the rest broken frames and
    // bursts of line noise in which start bytes show up often.
    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  none [$];
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(FLAW_NONE, none);
            else if (pick < 68)
                send_frame(FLAW_CHECKSUM, none);
            else if (pick < 75)
                send_frame(FLAW_TAIL, none);
            else if (pick < 80)
                send_frame(FLAW_HDR1, none);
            else if (pick < 85)
                send_frame(FLAW_HDR2, none);
            else
            begin
                n = $urandom_range(6, 1);
                repeat (n)
                    send_byte(($urandom_range(3) == 0) ? SOF_BYTE : 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] corner_body [$];
        logic [7:0] none [$];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with buff mode on: plain noise, a start byte followed
        // by a second start byte (which must not restart the frame), header
        // bytes out of order, and one good frame with extreme field values.
        send_idle_pct = 23;
        recv_idle_pct = 85;
        write_reg(BUFF_MODE_ADDR, 32'd1);
        sb.set_buff_mode(1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SOF_BYTE);
        send_byte(SOF_BYTE);
        send_byte(SOF_BYTE);
        send_byte(HDR2_BYTE);
        send_byte(SOF_BYTE);
        send_byte(HDR1_BYTE);
        send_byte(HDR1_BYTE);
        // Pitch -32768, yaw +32767, byte 7 and byte 8 all ones, aim at both ends.
        corner_body = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_frame(FLAW_NONE, corner_body);
        in_valid <= 1'b0;

        // Fast sender first, busy receiver, buff mode off.
        set_buff_mode(1'b0);
        random_traffic(PHASE_BYTES);
        in_valid <= 1'b0;

        // Swap the idle rates and turn buff mode back on.
        set_buff_mode(1'b1);
        send_idle_pct = 85;
        recv_idle_pct = 23;
        random_traffic(PHASE_BYTES);
        in_valid <= 1'b0;

        // Full rate on both sides. The receiver holds off for a long stretch
        // right away while the sender keeps offering bytes.
        set_buff_mode(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        random_traffic(PHASE_BYTES);
        send_frame(FLAW_NONE, none);
        in_valid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, checked %0d status beats: %0d good frames (%0d in buff mode),",
                 bytes_sent, sb.beats_checked, sb.frames_good, sb.frames_buff);
        $display("%0d dropped; both idle orders, full rate, a long output hold and both modes ran.",
                 sb.frames_dropped);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("%0d mismatches, %0d status beats never arrived", sb.mismatches, sb.pending());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
